### hdl/lmsct_pkg.sv
// Shared types, codes and helpers for the LMS linear classifier trainer.
// No dependencies; imported by the top level.

package lmsct_pkg;

	// Item kinds carried in the input tuser field.
	localparam logic [1:0] KIND_FEATURE = 2'd0;
	localparam logic [1:0] KIND_WEIGHT  = 2'd1;
	localparam logic [1:0] KIND_BIAS    = 2'd2;

	// Configuration register indexes.
	localparam int         CFG_IDX_W         = 1;
	localparam logic [0:0] CFG_LEARNING_RATE = 1'b0;
	localparam logic [0:0] CFG_CLASS_COUNT   = 1'b1;
	localparam int         CFG_DATA_W        = 16;

	// Stream word widths, padded to whole bytes.
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 72;

	// Reset values of the configuration registers.
	localparam logic [15:0] LEARNING_RATE_RST = 16'd655;
	localparam logic [4:0]  CLASS_COUNT_RST   = 5'd5;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_PRED,
		ST_ERR,
		ST_RE_MUL,
		ST_RE,
		ST_UPD_MUL,
		ST_UPD_WR,
		ST_EMIT
	} state_t;

	// Saturate a wide signed value to the 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic signed [31:0] r;
		if (v > 50'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -50'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### hdl/lmsct_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies; used for the weight store and the feature buffer.

module lmsct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/lms_linear_classifier_trainer.sv
// Top level of the LMS linear classifier trainer: stream ports, sequencer,
// shared multiplier and update datapath. Depends on lmsct_pkg and lmsct_ram.

// One linear neuron trained with the Widrow-Hoff rule. Feature words enter
// one element at a time; each is buffered and its product with the stored
// weight is added to the dot accumulator. The element marked last produces
// one result word (prediction, clamped class, error); with train set, all
// weights and the bias are then updated. All products go through a single
// 33x17 multiplier with a registered output, and the weights and features sit
// in memories with one write port and one registered read port. A weight, bias
// or unused word is handled in the idle state alone; a feature element in range
// is multiplied, then accumulated; a last element then goes on to prediction and
// error (straight from idle when its index lies outside the vector), and a
// trained vector then forms the rate-error product and its rounding, then per
// weight a multiply step and a saturate-and-write-back step. The input is not
// ready while an item is being worked on; a finished result waits in the output
// register and the next item is taken meanwhile. A second result holds the
// sequencer in its emit step until the first one has been taken.

module lms_linear_classifier_trainer
	import lmsct_pkg::*;
#(
	parameter int NUM_FEATURES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// index[3:0], feature[19:4], train[20], target[52:21], load_value[84:53], zero fill
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// kind[1:0]
	input  logic [1:0]             s_axis_tuser,
	input  logic                   s_axis_tlast,
	// Result stream.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// prediction[31:0], predicted_class[35:32], error_value[67:36], zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_FEATURES - 1);

	// Input word fields.
	logic [1:0]         in_kind;
	logic [3:0]         in_index;
	logic signed [15:0] in_feature;
	logic               in_train;
	logic signed [31:0] in_target;
	logic signed [31:0] in_load;
	logic [8:0]         index_ext;
	logic               in_range;
	logic [AW-1:0]      in_addr;
	logic               accept;

	// Sequencer and control registers.
	state_t             state_q, state_d;
	logic [AW-1:0]      cnt_q;
	logic [NUM_FEATURES-1:0] wvalid_q;
	logic signed [47:0] acc_q;
	logic signed [31:0] bias_q;
	logic [15:0]        lr_q;
	logic [4:0]         cc_q;
	logic               m_valid_q;

	// Datapath registers.
	logic signed [15:0] feat_q;
	logic               last_q;
	logic               train_q;
	logic signed [31:0] target_q;
	logic signed [49:0] prod_q;
	logic signed [31:0] pred_q;
	logic signed [31:0] err_q;
	logic [3:0]         cls_q;
	logic signed [31:0] re_q;
	logic signed [31:0] wold_q;
	logic               wvld_q;
	logic signed [31:0] out_pred_q;
	logic [3:0]         out_cls_q;
	logic signed [31:0] out_err_q;

	// Memory ports.
	logic               w_we;
	logic [AW-1:0]      w_waddr;
	logic signed [31:0] w_wdata;
	logic [31:0]        w_rd;
	logic               f_we;
	logic [15:0]        f_rd;
	logic [AW-1:0]      rd_addr;

	// Arithmetic.
	logic signed [31:0] w_cur;
	logic signed [32:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [49:0] mul_p;
	logic signed [49:0] rnd14;
	logic signed [49:0] rnd16;
	logic signed [47:0] term;
	logic signed [31:0] re_next;
	logic signed [31:0] bias_new;
	logic signed [31:0] w_new;
	logic signed [49:0] pred_sum;
	logic signed [49:0] err_diff;
	logic signed [32:0] cls_rnd;
	logic [3:0]         top_m1;
	logic [3:0]         cls_next;
	logic               out_free;

	// Unpack the input word.
	assign in_kind    = s_axis_tuser;
	assign in_index   = s_axis_tdata[3:0];
	assign in_feature = s_axis_tdata[19:4];
	assign in_train   = s_axis_tdata[20];
	assign in_target  = s_axis_tdata[52:21];
	assign in_load    = s_axis_tdata[84:53];
	assign index_ext  = {5'd0, in_index};
	assign in_range   = index_ext < 9'(NUM_FEATURES);
	assign in_addr    = index_ext[AW-1:0];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// Weight store and feature buffer.
	lmsct_ram #(.WIDTH(32), .DEPTH(NUM_FEATURES)) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.raddr (rd_addr),
		.rdata (w_rd)
	);

	lmsct_ram #(.WIDTH(16), .DEPTH(NUM_FEATURES)) u_feature_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (in_addr),
		.wdata (in_feature),
		.raddr (rd_addr),
		.rdata (f_rd)
	);

	// A weight never written since reset reads as zero.
	assign w_cur = wvld_q ? $signed(w_rd) : 32'sd0;

	// Shared multiplier operand selection.
	always_comb begin
		case (state_q)
			ST_RE_MUL: begin
				mul_a = {err_q[31], err_q};
				mul_b = $signed({1'b0, lr_q});
			end
			ST_UPD_MUL: begin
				mul_a = {re_q[31], re_q};
				mul_b = $signed({f_rd[15], f_rd});
			end
			default: begin
				mul_a = {w_cur[31], w_cur};
				mul_b = {feat_q[15], feat_q};
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Rounding shifts of the registered product.
	assign rnd14   = prod_q + 50'sd8192;
	assign rnd16   = prod_q + 50'sd32768;
	assign term    = {{12{rnd14[49]}}, rnd14[49:14]};
	assign re_next = rnd16[47:16];

	// Saturated updates, prediction and error.
	assign bias_new = sat32({{18{bias_q[31]}}, bias_q} - {{18{re_next[31]}}, re_next});
	assign w_new    = sat32({{18{wold_q[31]}}, wold_q} - {{14{rnd14[49]}}, rnd14[49:14]});
	assign pred_sum = {{18{bias_q[31]}}, bias_q} + {{2{acc_q[47]}}, acc_q};
	assign err_diff = {{18{pred_q[31]}}, pred_q} - {{18{target_q[31]}}, target_q};

	// Class: round half up, then clamp to 0..class_count-1; a class count of 0 acts as 1, one above 16 as 16.
	assign cls_rnd = {pred_q[31], pred_q} + 33'sd32768;

	always_comb begin
		if (cc_q == 5'd0) begin
			top_m1 = 4'd0;
		end else if (cc_q > 5'd16) begin
			top_m1 = 4'd15;
		end else begin
			top_m1 = 4'(cc_q - 5'd1);
		end
		if (cls_rnd[32]) begin
			cls_next = 4'd0;
		end else if (cls_rnd[32:16] > {13'd0, top_m1}) begin
			cls_next = top_m1;
		end else begin
			cls_next = cls_rnd[19:16];
		end
	end

	// Next state and memory control.
	always_comb begin
		state_d = state_q;
		w_we    = 1'b0;
		w_waddr = cnt_q;
		w_wdata = w_new;
		f_we    = 1'b0;
		rd_addr = cnt_q;
		case (state_q)
			ST_IDLE: begin
				rd_addr = in_addr;
				if (accept) begin
					case (in_kind)
						KIND_FEATURE: begin
							if (in_range) begin
								f_we    = 1'b1;
								state_d = ST_MUL;
							end else if (s_axis_tlast) begin
								state_d = ST_PRED;
							end
						end
						KIND_WEIGHT: begin
							w_we    = in_range;
							w_waddr = in_addr;
							w_wdata = in_load;
						end
						default: ;
					endcase
				end
			end
			ST_MUL:     state_d = ST_ACC;
			ST_ACC:     state_d = last_q ? ST_PRED : ST_IDLE;
			ST_PRED:    state_d = ST_ERR;
			ST_ERR:     state_d = train_q ? ST_RE_MUL : ST_EMIT;
			ST_RE_MUL:  state_d = ST_RE;
			ST_RE: begin
				rd_addr = '0;
				state_d = ST_UPD_MUL;
			end
			ST_UPD_MUL: state_d = ST_UPD_WR;
			ST_UPD_WR: begin
				w_we = 1'b1;
				if (cnt_q == LAST_ADDR) begin
					state_d = ST_EMIT;
				end else begin
					rd_addr = cnt_q + 1'b1;
					state_d = ST_UPD_MUL;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state, weight valid bits, accumulator, bias and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			wvalid_q  <= '0;
			acc_q     <= '0;
			bias_q    <= '0;
			lr_q      <= LEARNING_RATE_RST;
			cc_q      <= CLASS_COUNT_RST;
			m_valid_q <= 1'b0;
		end else begin
			if (w_we) begin
				wvalid_q[w_waddr] <= 1'b1;
			end
			if (state_q == ST_RE) begin
				cnt_q <= '0;
			end else if (state_q == ST_UPD_WR && cnt_q != LAST_ADDR) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ST_ACC) begin
				acc_q <= acc_q + term;
			end else if (state_q == ST_PRED) begin
				acc_q <= '0;
			end
			if (accept && in_kind == KIND_BIAS) begin
				bias_q <= in_load;
			end else if (state_q == ST_RE) begin
				bias_q <= bias_new;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_LEARNING_RATE: lr_q <= cfg_data;
					CFG_CLASS_COUNT:   cc_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (state_q == ST_EMIT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			feat_q   <= in_feature;
			last_q   <= s_axis_tlast;
			train_q  <= in_train;
			target_q <= in_target;
		end
		wvld_q <= wvalid_q[rd_addr];
		prod_q <= mul_p;
		if (state_q == ST_PRED) begin
			pred_q <= sat32(pred_sum);
		end
		if (state_q == ST_ERR) begin
			err_q <= sat32(err_diff);
			cls_q <= cls_next;
		end
		if (state_q == ST_RE) begin
			re_q <= re_next;
		end
		if (state_q == ST_UPD_MUL) begin
			wold_q <= w_cur;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_pred_q <= pred_q;
			out_cls_q  <= cls_q;
			out_err_q  <= err_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'd0, out_err_q, out_cls_q, out_pred_q};

	// A result word appears only when the sequencer hands one over.
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_EMIT))
		else $error("result word raised outside the emit step");

	// The accumulator is empty after every prediction.
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRED) |=> (acc_q == 48'sd0))
		else $error("dot accumulator not cleared after prediction");

	// The update sweep stays inside the weight store.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD_MUL || state_q == ST_UPD_WR) |-> (cnt_q <= LAST_ADDR))
		else $error("update counter out of range");

	// A finished update sweep leaves every weight written.
	a_sweep_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD_WR && cnt_q == LAST_ADDR) |=> (&wvalid_q))
		else $error("update sweep skipped a weight");

endmodule

### tb/lmsct_checker.sv
// Checker for the LMS linear classifier trainer: watches the input, result and
// register write ports, predicts every result word and compares it field by field.
// Depends on lmsct_pkg for widths, word kinds and register indexes.
`timescale 1ns / 100ps

module lmsct_checker
	import lmsct_pkg::*;
#(
	parameter int NUM_FEATURES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	// index[3:0], feature[19:4], train[20], target[52:21], load_value[84:53], zero fill
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// kind[1:0]
	input  logic [1:0]             s_axis_tuser,
	input  logic                   s_axis_tlast,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// prediction[31:0], predicted_class[35:32], error_value[67:36], zero fill
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     outstanding,
	output int                     result_count,
	output int                     trained_count
);

	localparam longint MAX32 = 64'sh0000_0000_7fff_ffff;
	localparam longint MIN32 = -MAX32 - 1;

	typedef struct packed {
		logic signed [31:0] prediction;
		logic [3:0]         predicted_class;
		logic signed [31:0] error_value;
	} result_t;

	// Predicted neuron state, kept in step with the block.
	logic signed [31:0] weights [NUM_FEATURES];
	logic signed [31:0] bias;
	logic signed [15:0] feature_buf [NUM_FEATURES];
	longint             dot_sum;
	logic [15:0]        rate;
	logic [4:0]         classes;
	result_t            due_results [$];

	// Arithmetic shift right by n with rounding half up.
	function automatic longint round_off(input longint v, input int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clip32(input longint v);
		longint r;
		r = v;
		if (v > MAX32) begin
			r = MAX32;
		end else if (v < MIN32) begin
			r = MIN32;
		end
		return r;
	endfunction

	function automatic void flag_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Apply one accepted input word; the last element of a vector queues its result.
	task automatic neuron_step(input logic [IN_TDATA_W-1:0] d, input logic [1:0] kind,
			input logic last);
		logic [3:0]         idx;
		logic signed [15:0] feat;
		logic               train;
		logic signed [31:0] target;
		logic signed [31:0] load;
		longint             pred;
		longint             err;
		longint             step;
		longint             cls;
		int                 top;
		result_t            r;
		idx    = d[3:0];
		feat   = d[19:4];
		train  = d[20];
		target = d[52:21];
		load   = d[84:53];
		case (kind)
			KIND_WEIGHT: begin
				if (idx < NUM_FEATURES) begin
					weights[idx] = load;
				end
			end
			KIND_BIAS: begin
				bias = load;
			end
			KIND_FEATURE: begin
				if (idx < NUM_FEATURES) begin
					feature_buf[idx] = feat;
					dot_sum += round_off(longint'(weights[idx]) * longint'(feat), 14);
				end
				if (last) begin
					pred = clip32(longint'(bias) + dot_sum);
					dot_sum = 0;
					// Out-of-range class counts behave as 1 or 16.
					top = (classes == 0) ? 1 : ((classes > 16) ? 16 : int'(classes));
					cls = (pred + 32768) >>> 16;
					if (cls < 0) begin
						cls = 0;
					end
					if (cls > top - 1) begin
						cls = top - 1;
					end
					err = clip32(pred - longint'(target));
					// Widrow-Hoff update over every buffered position.
					if (train) begin
						step = round_off(longint'(rate) * err, 16);
						for (int i = 0; i < NUM_FEATURES; i++) begin
							weights[i] = clip32(longint'(weights[i])
								- round_off(step * longint'(feature_buf[i]), 14));
						end
						bias = clip32(longint'(bias) - step);
						trained_count++;
					end
					r.prediction      = pred[31:0];
					r.predicted_class = cls[3:0];
					r.error_value     = err[31:0];
					due_results.push_back(r);
				end
			end
			default: begin
				// Unused kind: ignored.
			end
		endcase
	endtask

	task automatic check_word(input logic [OUT_TDATA_W-1:0] d);
		result_t want;
		result_count++;
		if (due_results.size() == 0) begin
			$display("%0t: result word %h arrived with none expected", $time, d);
			fail_count++;
		end else begin
			want = due_results.pop_front();
			flag_field("prediction", want.prediction, d[31:0]);
			flag_field("predicted_class", 32'(want.predicted_class), 32'(d[35:32]));
			flag_field("error_value", want.error_value, d[67:36]);
		end
	endtask

	// Sample all three ports at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FEATURES; i++) begin
				weights[i]     = '0;
				feature_buf[i] = '0;
			end
			bias          = '0;
			dot_sum       = 0;
			rate          = LEARNING_RATE_RST;
			classes       = CLASS_COUNT_RST;
			fail_count    = 0;
			result_count  = 0;
			trained_count = 0;
			due_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_LEARNING_RATE) begin
					rate = cfg_data[15:0];
				end else if (cfg_index == CFG_CLASS_COUNT) begin
					classes = cfg_data[4:0];
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				check_word(m_axis_tdata);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				neuron_step(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			end
			outstanding <= due_results.size();
		end
	end

endmodule

### tb/tb_top.sv
// Testbench top for the LMS linear classifier trainer: clock, reset, input and
// register stimulus, result back-pressure and the verdict.
// Depends on lmsct_pkg, lmsct_checker and the trainer RTL.
`timescale 1ns / 100ps

module tb_top
	import lmsct_pkg::*;
();

	localparam int NUM_FEATURES = 16;
	// A trained vector keeps the block busy through the update sweep that follows the
	// acceptance of its last element.
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 400;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]         kind;
		logic [3:0]         index;
		logic signed [15:0] feature;
		logic               last;
		logic               train;
		logic signed [31:0] target;
		logic signed [31:0] load_value;
	} item_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [1:0]             s_axis_tuser = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int fail_count;
	int outstanding;
	int result_count;
	int trained_count;
	int word_count = 0;
	int setting_count = 1;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit rx_hold_req = 1'b0;

	// Register settings per random phase, extremes and out-of-range class counts included.
	logic [15:0] rate_set [6] = '{16'd65535, 16'd0, 16'd1, 16'd32768, 16'd655, 16'd3000};
	logic [4:0]  class_set [6] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd10, 5'd16};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	lms_linear_classifier_trainer #(
		.NUM_FEATURES(NUM_FEATURES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	lmsct_checker #(
		.NUM_FEATURES(NUM_FEATURES)
	) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.result_count (result_count),
		.trained_count(trained_count)
	);

	// Idle length: mostly none, sometimes short, rarely a long stretch.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Weights mostly within +-4.0 so predictions land among the classes.
	function automatic logic signed [31:0] pick_weight();
		int v;
		if ($urandom_range(0, 4) != 0) begin
			v = $urandom_range(0, 524288);
			return v - 262144;
		end
		return $urandom;
	endfunction

	function automatic logic signed [31:0] pick_target();
		int c;
		int n;
		if ($urandom_range(0, 9) < 7) begin
			c = $urandom_range(0, 16);
			n = $urandom_range(0, 65535);
			return c * 65536 + n - 32768;
		end
		return $urandom;
	endfunction

	// Every field random; callers overwrite the ones that matter.
	function automatic item_t noise_item();
		item_t it;
		it.kind       = 2'($urandom_range(0, 3));
		it.index      = 4'($urandom);
		it.feature    = 16'($urandom);
		it.last       = 1'($urandom);
		it.train      = 1'($urandom);
		it.target     = $urandom;
		it.load_value = $urandom;
		return it;
	endfunction

	function automatic item_t feat_item(input int idx, input logic signed [15:0] f,
			input logic last, input logic train, input logic signed [31:0] target);
		item_t it;
		it         = noise_item();
		it.kind    = KIND_FEATURE;
		it.index   = 4'(idx);
		it.feature = f;
		it.last    = last;
		it.train   = train;
		it.target  = target;
		return it;
	endfunction

	// Offer one word and hold it until the block takes it.
	task automatic send(input item_t it);
		int gap;
		gap = tx_steady ? 0 : idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, it.load_value, it.target, it.train, it.feature, it.index};
		s_axis_tuser  <= it.kind;
		s_axis_tlast  <= it.last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (it.kind != KIND_UNUSED) begin
			word_count++;
		end
	endtask

	task automatic send_weight(input int idx, input logic signed [31:0] value);
		item_t it;
		it            = noise_item();
		it.kind       = KIND_WEIGHT;
		it.index      = 4'(idx);
		it.load_value = value;
		send(it);
	endtask

	task automatic send_bias(input logic signed [31:0] value);
		item_t it;
		it            = noise_item();
		it.kind       = KIND_BIAS;
		it.load_value = value;
		send(it);
	endtask

	// One vector: full or partial, positions in shuffled order, an occasional
	// weight write slipped in between elements.
	task automatic send_vector();
		int len;
		int j;
		int t;
		int slot [NUM_FEATURES];
		len = ($urandom_range(0, 9) < 3) ? NUM_FEATURES : $urandom_range(1, NUM_FEATURES);
		for (int k = 0; k < NUM_FEATURES; k++) begin
			slot[k] = k;
		end
		for (int k = NUM_FEATURES - 1; k > 0; k--) begin
			j       = $urandom_range(0, k);
			t       = slot[k];
			slot[k] = slot[j];
			slot[j] = t;
		end
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 29) == 0) begin
				send_weight(slot[k], pick_weight());
			end
			send(feat_item(slot[k], 16'($urandom), k == len - 1,
				$urandom_range(0, 2) != 0, pick_target()));
		end
	endtask

	// Mostly whole vectors, the rest loads, unused words and stray elements.
	task automatic random_phase(input int n);
		int start;
		int pick;
		item_t it;
		start = word_count;
		while (word_count - start < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 78) begin
				send_vector();
			end else if (pick < 86) begin
				send_weight($urandom_range(0, NUM_FEATURES - 1), pick_weight());
			end else if (pick < 91) begin
				send_bias(pick_weight());
			end else if (pick < 95) begin
				it      = noise_item();
				it.kind = KIND_UNUSED;
				send(it);
			end else begin
				// Elements without last run on into the next vector.
				repeat ($urandom_range(1, 3)) begin
					send(feat_item($urandom_range(0, NUM_FEATURES - 1), 16'($urandom),
						1'b0, 1'($urandom), $urandom));
				end
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering, wait for every predicted result, then let the block go idle.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: random stalls, a steady mode, and one long hold on request.
	initial begin : result_sink
		int stall;
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (rx_steady) begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				stall = idle_len();
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		item_t it;
		logic signed [15:0] f;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run at the reset register values.
		it      = noise_item();
		it.kind = KIND_UNUSED;
		send(it);
		send_weight(0, 32'sh7fffffff);
		send_weight(NUM_FEATURES - 1, 32'sh80000000);
		send_bias(32'sh7fff0000);
		// Full vector with extreme features: saturates prediction and error upward,
		// a weight rewritten mid-vector, and every buffer position filled.
		for (int i = 0; i < NUM_FEATURES; i++) begin
			if (i == NUM_FEATURES / 2) begin
				send_weight(i, 32'sh00018000);
			end
			if (i == 0) begin
				f = 16'sh7fff;
			end else if (i == NUM_FEATURES - 1) begin
				f = 16'sh8000;
			end else begin
				f = 16'($urandom);
			end
			send(feat_item(i, f, i == NUM_FEATURES - 1, 1'b0, 32'sh80000000));
		end
		// One-element vector with training: the update reads older buffer entries.
		send(feat_item(3, 16'sh4000, 1'b1, 1'b1, 32'sh0));
		// Prediction exactly 2.5 rounds up to class 3.
		send_bias(32'sh00028000);
		send(feat_item(5, 16'sh0000, 1'b1, 1'b0, $urandom));
		// Most negative prediction: class 0, error saturates downward.
		send_bias(32'sh80000000);
		send(feat_item(2, 16'sh0000, 1'b1, 1'b0, 32'sh7fffffff));
		settle();

		// Random phases, one register setting each.
		for (int p = 0; p < 6; p++) begin
			write_reg(CFG_LEARNING_RATE, rate_set[p]);
			write_reg(CFG_CLASS_COUNT, CFG_DATA_W'(class_set[p]));
			setting_count++;
			tx_steady = (p == 4);
			rx_steady = (p == 4);
			if (p == 2) begin
				random_phase(60);
				rx_hold_req = 1'b1;
				random_phase(57);
			end else if (p == 3) begin
				random_phase(60);
				settle();
				random_phase(57);
			end else begin
				random_phase(117);
			end
			settle();
		end

		$display("Run covered %0d input words and %0d result words, %0d from trained vectors,",
			word_count, result_count, trained_count);
		$display("across %0d register settings with rate and class-count extremes.",
			setting_count);
		if (fail_count == 0) begin
			$display("lms_linear_classifier_trainer: match");
		end else begin
			$display("lms_linear_classifier_trainer: mismatch");
		end
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("Timed out with %0d result words still expected.", outstanding);
		$display("lms_linear_classifier_trainer: mismatch");
		$finish;
	end

endmodule
